// ----- design/msi_coherent_line_controller_macros.svh -----
// assertion macros shared by the msi line controller
`ifndef MSI_COHERENT_LINE_CONTROLLER_MACROS_SVH
`define MSI_COHERENT_LINE_CONTROLLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MSI_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msi controller check failed");

// next-cycle implication, checked outside reset
`define MSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msi controller check failed");

`endif

// ----- design/msi_pkg.sv -----
// types and constants of the msi line controller
package msi_pkg;

  localparam int ADDR_BITS_DEF = 32;
  localparam int PORT_ADDR_W   = 32;
  localparam int DATA_W        = 8;
  localparam int ID_W          = 4;
  localparam int MAX_RESULTS   = 3;
  localparam int CFG_ADDR_W    = 3;

  typedef enum logic [1:0] {
    CMD_CPU   = 2'd0,
    CMD_GRANT = 2'd1,
    CMD_MEM   = 2'd2,
    CMD_SNOOP = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_CPU_RESP = 3'd0,
    ACT_BUS_REQ  = 3'd1,
    ACT_MEM_REQ  = 3'd2,
    ACT_WB       = 3'd3,
    ACT_RELEASE  = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_M = 2'd2
  } line_state_t;

  typedef enum logic {
    REG_CACHE_ID = 1'b0
  } reg_idx_t;

  typedef struct packed {
    action_t           action;
    logic [PORT_ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              to_mem;
    logic [ID_W-1:0]   req;
  } result_t;

  // all words caused by one event, count of zero means none
  typedef struct packed {
    logic [1:0]                  count;
    result_t [MAX_RESULTS-1:0]   res;
  } bundle_t;

endpackage

// ----- design/msi_core.sv -----
// line state, pending request and per-event protocol logic
module msi_core #(
  parameter int ADDR_BITS = msi_pkg::ADDR_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [msi_pkg::ID_W-1:0] cache_id,
  input  msi_pkg::cmd_t            cmd,
  input  logic                     rd,
  input  logic [ADDR_BITS-1:0]     addr,
  input  logic [msi_pkg::DATA_W-1:0] wd,
  input  logic [msi_pkg::DATA_W-1:0] md,
  output msi_pkg::bundle_t         bundle
);
  import msi_pkg::*;

  line_state_t          line_state, line_state_next;
  logic [ADDR_BITS-1:0] line_tag, line_tag_next;
  logic [DATA_W-1:0]    line_data, line_data_next;
  logic                 line_dirty, line_dirty_next;
  logic                 pending_is_read, pending_is_read_next;
  logic [ADDR_BITS-1:0] pending_address, pending_address_next;
  logic [DATA_W-1:0]    pending_write_data, pending_write_data_next;
  logic                 busy, busy_next;

  logic hit_a, hit_p;
  logic [1:0] n;

  assign hit_a = (line_state != ST_I) && (line_tag == addr);
  assign hit_p = (line_state != ST_I) && (line_tag == pending_address);

  // event decode, next state and result words
  always_comb begin
    line_state_next         = line_state;
    line_tag_next           = line_tag;
    line_data_next          = line_data;
    line_dirty_next         = line_dirty;
    pending_is_read_next    = pending_is_read;
    pending_address_next    = pending_address;
    pending_write_data_next = pending_write_data;
    busy_next               = busy;
    bundle                  = '0;
    n                       = 2'd0;
    case (cmd)
      CMD_CPU: begin
        if (!busy) begin
          busy_next    = 1'b1;
          bundle.count = 2'd1;
          if (hit_a && rd) begin
            bundle.res[0] = '{ACT_CPU_RESP, PORT_ADDR_W'(addr), line_data, 1'b0, '0};
            busy_next = 1'b0;
          end else if (hit_a) begin
            line_dirty_next = 1'b1;
            line_data_next  = wd;
            if (line_state == ST_S) begin
              // upgrade: keep the byte for the later fill
              pending_is_read_next    = 1'b0;
              pending_address_next    = addr;
              pending_write_data_next = wd;
              bundle.res[0] = '{ACT_BUS_REQ, PORT_ADDR_W'(addr), '0, 1'b0, cache_id};
            end else begin
              bundle.res[0] = '{ACT_CPU_RESP, PORT_ADDR_W'(addr), '0, 1'b0, '0};
              busy_next = 1'b0;
            end
          end else begin
            pending_is_read_next = rd;
            pending_address_next = addr;
            if (!rd) begin
              pending_write_data_next = wd;
            end
            bundle.res[0] = '{ACT_BUS_REQ, PORT_ADDR_W'(addr), '0, 1'b0, cache_id};
          end
        end
      end
      CMD_GRANT: begin
        if (busy) begin
          bundle.count  = 2'd1;
          bundle.res[0] = '{ACT_MEM_REQ, PORT_ADDR_W'(pending_address), '0,
                            pending_is_read, cache_id};
        end
      end
      CMD_MEM: begin
        if (busy) begin
          if (!hit_p) begin
            // evict a dirty modified victim first
            if (line_state == ST_M && line_dirty) begin
              bundle.res[0] = '{ACT_WB, PORT_ADDR_W'(line_tag), line_data, 1'b0, cache_id};
              n = 2'd1;
            end
            line_tag_next   = pending_address;
            line_dirty_next = 1'b0;
          end
          if (pending_is_read) begin
            line_data_next  = md;
            line_state_next = ST_S;
            bundle.res[n] = '{ACT_CPU_RESP, PORT_ADDR_W'(pending_address), md, 1'b0, '0};
          end else begin
            line_data_next  = pending_write_data;
            line_dirty_next = 1'b1;
            line_state_next = ST_M;
            bundle.res[n] = '{ACT_CPU_RESP, PORT_ADDR_W'(pending_address), '0, 1'b0, '0};
          end
          bundle.res[2'(n + 2'd1)] = '{ACT_RELEASE, PORT_ADDR_W'(pending_address), '0,
                                      1'b0, cache_id};
          bundle.count = 2'(n + 2'd2);
          busy_next    = 1'b0;
        end
      end
      CMD_SNOOP: begin
        if (hit_a) begin
          if (line_state == ST_M && line_dirty) begin
            bundle.res[0]   = '{ACT_WB, PORT_ADDR_W'(line_tag), line_data, 1'b0, cache_id};
            bundle.count    = 2'd1;
            line_dirty_next = 1'b0;
          end
          if (rd) begin
            if (line_state == ST_M) begin
              line_state_next = ST_S;
            end
          end else begin
            line_state_next = ST_I;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // state registers, updated when an event is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      line_state         <= ST_I;
      line_tag           <= '0;
      line_data          <= '0;
      line_dirty         <= 1'b0;
      pending_is_read    <= 1'b0;
      pending_address    <= '0;
      pending_write_data <= '0;
      busy               <= 1'b0;
    end else if (en) begin
      line_state         <= line_state_next;
      line_tag           <= line_tag_next;
      line_data          <= line_data_next;
      line_dirty         <= line_dirty_next;
      pending_is_read    <= pending_is_read_next;
      pending_address    <= pending_address_next;
      pending_write_data <= pending_write_data_next;
      busy               <= busy_next;
    end
  end

endmodule

// ----- design/msi_outq.sv -----
// result register that hands out one word of a bundle per cycle unless the output is stalled
module msi_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  msi_pkg::bundle_t bundle_in,
  input  logic             stall,
  output logic             valid,
  output msi_pkg::result_t word,
  output logic             last,
  output logic             free
);
  import msi_pkg::*;

  bundle_t    held;
  logic [1:0] idx;
  logic       accept;

  assign accept = valid && !stall;
  assign last   = (idx == 2'(held.count - 2'd1));
  assign free   = !valid || (accept && last);
  assign word   = held.res[idx];

  // bundle hold and word index
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (accept && last) begin
      valid <= 1'b0;
    end else if (accept) begin
      idx <= 2'(idx + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle_in;
    end
  end

endmodule

// ----- design/msi_coherent_line_controller.sv -----
// top level of the msi line controller: input register, config port, core, result queue
// One event is taken per cycle unless the input is stalled. Each event is registered,
// then processed by the protocol logic, which updates the line and pending request and
// loads its result words (none, one, or up to three for a memory response: writeback,
// cpu response, bus release) into the result register. Words leave one per cycle unless
// the output is stalled; events that make no words never wait on the output.
// cache_id is at byte address 0 of the config port and should be written while idle.
module msi_coherent_line_controller #(
  parameter int ADDR_BITS = msi_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // config port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msi_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  // event channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      command,
  input  logic                            is_read,
  input  logic [msi_pkg::PORT_ADDR_W-1:0] address,
  input  logic [msi_pkg::DATA_W-1:0]      write_data,
  input  logic [msi_pkg::DATA_W-1:0]      mem_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      action,
  output logic [msi_pkg::PORT_ADDR_W-1:0] out_address,
  output logic [msi_pkg::DATA_W-1:0]      out_data,
  output logic                            to_memory,
  output logic [msi_pkg::ID_W-1:0]        requester,
  output logic                            last
);
  import msi_pkg::*;
  `include "msi_coherent_line_controller_macros.svh"

  logic [ID_W-1:0]      cache_id;
  logic                 cfg_sel;

  logic                 s1_valid;
  cmd_t                 s1_cmd;
  logic                 s1_rd;
  logic [ADDR_BITS-1:0] s1_addr;
  logic [DATA_W-1:0]    s1_wd;
  logic [DATA_W-1:0]    s1_md;
  logic                 s1_adv;
  logic                 in_accept;

  bundle_t              bundle;
  logic                 bundle_load;
  logic                 oq_free;
  result_t              word;

  // config register
  assign pready  = 1'b1;
  assign cfg_sel = (reg_idx_t'(paddr[2]) == REG_CACHE_ID);
  assign prdata  = cfg_sel ? 32'(cache_id) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_id <= '0;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      cache_id <= pwdata[ID_W-1:0];
    end
  end

  // input register
  assign s1_adv      = s1_valid && ((bundle.count == 2'd0) || oq_free);
  assign bundle_load = s1_adv && (bundle.count != 2'd0);
  assign in_stall    = s1_valid && !s1_adv;
  assign in_accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_cmd  <= cmd_t'(command);
      s1_rd   <= is_read;
      s1_addr <= ADDR_BITS'(address);
      s1_wd   <= write_data;
      s1_md   <= mem_data;
    end
  end

  msi_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .en       (s1_adv),
    .cache_id (cache_id),
    .cmd      (s1_cmd),
    .rd       (s1_rd),
    .addr     (s1_addr),
    .wd       (s1_wd),
    .md       (s1_md),
    .bundle   (bundle)
  );

  msi_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .load      (bundle_load),
    .bundle_in (bundle),
    .stall     (out_stall),
    .valid     (out_valid),
    .word      (word),
    .last      (last),
    .free      (oq_free)
  );

  // result word fields
  assign action      = word.action;
  assign out_address = word.addr;
  assign out_data    = word.data;
  assign to_memory   = word.to_mem;
  assign requester   = word.req;

  // checks
  `MSI_ASSERT_NOW(a_load_only_when_free, clk, rst, bundle_load, oq_free)
  `MSI_ASSERT_NOW(a_empty_never_stalls, clk, rst, !s1_valid, !in_stall)
  `MSI_ASSERT_NEXT(a_drain_clears_valid, clk, rst,
                   out_valid && !out_stall && last && !bundle_load, !out_valid)

endmodule

// ----- bench/msi_line_checker.sv -----
// checker of the msi line controller: predicts every result word and compares it
`timescale 1ns / 1ps
module msi_line_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [msi_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  input  logic                            pready,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [1:0]                      command,
  input  logic                            is_read,
  input  logic [msi_pkg::PORT_ADDR_W-1:0] address,
  input  logic [msi_pkg::DATA_W-1:0]      write_data,
  input  logic [msi_pkg::DATA_W-1:0]      mem_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [2:0]                      action,
  input  logic [msi_pkg::PORT_ADDR_W-1:0] out_address,
  input  logic [msi_pkg::DATA_W-1:0]      out_data,
  input  logic                            to_memory,
  input  logic [msi_pkg::ID_W-1:0]        requester,
  input  logic                            last,
  output int                              error_count,
  output int                              pending_words,
  output int                              checked_words
);
  import msi_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CACHE_ID_ADDR = {REG_CACHE_ID, 2'b00};

  typedef struct packed {
    result_t word;
    logic    last;
  } line_word_t;

  // shadow of the line, the pending request and the register
  logic [ID_W-1:0]        cache_id;
  line_state_t            line_st;
  logic [PORT_ADDR_W-1:0] line_tag;
  logic [DATA_W-1:0]      line_byte;
  logic                   line_dirty;
  logic                   req_is_read;
  logic [PORT_ADDR_W-1:0] req_addr;
  logic [DATA_W-1:0]      req_byte;
  logic                   req_busy;

  line_word_t expected_words[$];
  result_t    event_words[$];
  int         fails;
  int         checked;

  function automatic logic line_hit(input logic [PORT_ADDR_W-1:0] a);
    return (line_st != ST_I) && (line_tag == a);
  endfunction

  task automatic emit(input action_t act, input logic [PORT_ADDR_W-1:0] a,
                      input logic [DATA_W-1:0] d, input logic tm, input logic [ID_W-1:0] rq);
    result_t w;
    w.action = act;
    w.addr   = a;
    w.data   = d;
    w.to_mem = tm;
    w.req    = rq;
    event_words.push_back(w);
  endtask

  // a modified dirty line goes out and becomes clean
  task automatic emit_writeback();
    if (line_st == ST_M && line_dirty) begin
      line_dirty = 1'b0;
      emit(ACT_WB, line_tag, line_byte, 1'b0, cache_id);
    end
  endtask

  // next state and result words of one accepted event
  task automatic apply_event(input cmd_t c, input logic rd, input logic [PORT_ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] wd, input logic [DATA_W-1:0] md);
    line_word_t             lw;
    logic [PORT_ADDR_W-1:0] pa;
    event_words.delete();
    case (c)
      CMD_CPU: begin
        if (!req_busy) begin
          req_busy = 1'b1;
          if (line_hit(a)) begin
            if (rd) begin
              emit(ACT_CPU_RESP, a, line_byte, 1'b0, '0);
              req_busy = 1'b0;
            end else begin
              line_dirty = 1'b1;
              line_byte  = wd;
              if (line_st == ST_S) begin
                // upgrade keeps the byte for the later fill
                req_is_read = 1'b0;
                req_addr    = a;
                req_byte    = wd;
                emit(ACT_BUS_REQ, a, '0, 1'b0, cache_id);
              end else begin
                emit(ACT_CPU_RESP, a, '0, 1'b0, '0);
                req_busy = 1'b0;
              end
            end
          end else begin
            req_is_read = rd;
            req_addr    = a;
            if (!rd) req_byte = wd;
            emit(ACT_BUS_REQ, a, '0, 1'b0, cache_id);
          end
        end
      end
      CMD_GRANT: begin
        if (req_busy) emit(ACT_MEM_REQ, req_addr, '0, req_is_read, cache_id);
      end
      CMD_MEM: begin
        if (req_busy) begin
          pa = req_addr;
          // a fill of another line evicts the current one first
          if (!line_hit(pa)) begin
            if (line_st == ST_M && line_dirty) begin
              emit_writeback();
              line_st = ST_I;
            end else if (line_st == ST_S) begin
              line_st = ST_I;
            end
            line_tag   = pa;
            line_dirty = 1'b0;
          end
          if (req_is_read) begin
            line_byte = md;
            line_st   = ST_S;
            emit(ACT_CPU_RESP, pa, line_byte, 1'b0, '0);
          end else begin
            line_byte  = req_byte;
            line_dirty = 1'b1;
            line_st    = ST_M;
            emit(ACT_CPU_RESP, pa, '0, 1'b0, '0);
          end
          emit(ACT_RELEASE, pa, '0, 1'b0, cache_id);
          req_busy = 1'b0;
        end
      end
      default: begin
        // remote read demotes, remote write invalidates
        if (line_hit(a)) begin
          if (rd) begin
            if (line_st == ST_M) begin
              emit_writeback();
              line_st = ST_S;
            end
          end else begin
            emit_writeback();
            line_st = ST_I;
          end
        end
      end
    endcase
    foreach (event_words[k]) begin
      lw.word = event_words[k];
      lw.last = (k == event_words.size() - 1);
      expected_words.push_back(lw);
    end
  endtask

  // compare one accepted result word with the oldest expectation
  task automatic check_word();
    line_word_t ew;
    if (expected_words.size() == 0) begin
      $error("unexpected result word: action %0d address %h", action, out_address);
      fails++;
    end else begin
      ew = expected_words.pop_front();
      checked++;
      if (action !== ew.word.action) begin
        $error("action: expected %0d, actual %0d", ew.word.action, action);
        fails++;
      end
      if (out_address !== ew.word.addr) begin
        $error("out_address: expected %h, actual %h", ew.word.addr, out_address);
        fails++;
      end
      if (out_data !== ew.word.data) begin
        $error("out_data: expected %h, actual %h", ew.word.data, out_data);
        fails++;
      end
      if (to_memory !== ew.word.to_mem) begin
        $error("to_memory: expected %0d, actual %0d", ew.word.to_mem, to_memory);
        fails++;
      end
      if (requester !== ew.word.req) begin
        $error("requester: expected %0d, actual %0d", ew.word.req, requester);
        fails++;
      end
      if (last !== ew.last) begin
        $error("last: expected %0d, actual %0d", ew.last, last);
        fails++;
      end
    end
  endtask

  // watch both channels and the config port
  always @(posedge clk) begin
    if (rst) begin
      cache_id    = '0;
      line_st     = ST_I;
      line_tag    = '0;
      line_byte   = '0;
      line_dirty  = 1'b0;
      req_is_read = 1'b0;
      req_addr    = '0;
      req_byte    = '0;
      req_busy    = 1'b0;
      expected_words.delete();
    end else begin
      if (out_valid && !out_stall) check_word();
      if (psel && penable && pwrite && pready && paddr == CACHE_ID_ADDR)
        cache_id = pwdata[ID_W-1:0];
      if (in_valid && !in_stall)
        apply_event(cmd_t'(command), is_read, address, write_data, mem_data);
    end
    error_count   <= fails;
    pending_words <= expected_words.size();
    checked_words <= checked;
  end

endmodule

// ----- bench/tb_msi_coherent_line_controller.sv -----
// testbench top of the msi line controller: stimulus, idling and verdict
`timescale 1ns / 1ps
module tb_msi_coherent_line_controller;
  import msi_pkg::*;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CHUNK_WORDS  = 78;
  localparam logic [CFG_ADDR_W-1:0] CACHE_ID_ADDR = {REG_CACHE_ID, 2'b00};

  logic                   clk;
  logic                   rst;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [CFG_ADDR_W-1:0]  paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  logic                   in_valid;
  logic                   in_stall;
  logic [1:0]             command;
  logic                   is_read;
  logic [PORT_ADDR_W-1:0] address;
  logic [DATA_W-1:0]      write_data;
  logic [DATA_W-1:0]      mem_data;
  logic                   out_valid;
  logic                   out_stall;
  logic [2:0]             action;
  logic [PORT_ADDR_W-1:0] out_address;
  logic [DATA_W-1:0]      out_data;
  logic                   to_memory;
  logic [ID_W-1:0]        requester;
  logic                   last;

  int error_count;
  int pending_words;
  int checked_words;
  int sent_words;
  int cycle_count;
  int settings_used;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  logic [PORT_ADDR_W-1:0] addr_pool [4];

  msi_coherent_line_controller i_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .is_read(is_read),
    .address(address), .write_data(write_data), .mem_data(mem_data),
    .out_valid(out_valid), .out_stall(out_stall), .action(action),
    .out_address(out_address), .out_data(out_data), .to_memory(to_memory),
    .requester(requester), .last(last)
  );

  msi_line_checker i_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .is_read(is_read),
    .address(address), .write_data(write_data), .mem_data(mem_data),
    .out_valid(out_valid), .out_stall(out_stall), .action(action),
    .out_address(out_address), .out_data(out_data), .to_memory(to_memory),
    .requester(requester), .last(last),
    .error_count(error_count), .pending_words(pending_words),
    .checked_words(checked_words)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = gaps_on && ($urandom_range(99) < 14);
      end
    end
  end

  function automatic logic [PORT_ADDR_W-1:0] pick_address();
    if ($urandom_range(99) < 85) return addr_pool[$urandom_range(3)];
    return $urandom;
  endfunction

  // offer one event word and wait until it is taken
  task automatic send_event(input cmd_t c, input logic rd, input logic [PORT_ADDR_W-1:0] a,
                            input logic [DATA_W-1:0] wd, input logic [DATA_W-1:0] md);
    @(negedge clk);
    if (gaps_on && $urandom_range(99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    command    = c;
    is_read    = rd;
    address    = a;
    write_data = wd;
    mem_data   = md;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_words++;
  endtask

  task automatic send_random(input cmd_t c);
    send_event(c, 1'($urandom_range(1)), pick_address(), 8'($urandom), 8'($urandom));
  endtask

  // mostly request, grant, fill with snoops in between; some noise
  task automatic rand_sequence();
    if ($urandom_range(99) < 15) begin
      send_random(cmd_t'($urandom_range(3)));
    end else begin
      send_random(CMD_CPU);
      if ($urandom_range(99) < 10) send_random(CMD_CPU);
      if ($urandom_range(99) < 40) send_random(CMD_SNOOP);
      send_random(CMD_GRANT);
      if ($urandom_range(99) < 30) send_random(CMD_SNOOP);
      send_random(CMD_MEM);
    end
  endtask

  task automatic write_cache_id(input logic [ID_W-1:0] id);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CACHE_ID_ADDR;
    pwdata  = 32'(id);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    settings_used++;
  endtask

  // stop offering, let every expected word arrive, then let the core settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [ID_W-1:0] id;
    int              target;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    command    = CMD_CPU;
    is_read    = 1'b0;
    address    = '0;
    write_data = '0;
    mem_data   = '0;
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = $urandom;
    addr_pool[3] = $urandom;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed walk through the protocol
    write_cache_id(4'hF);
    // grant and fill with nothing pending are dropped
    send_event(CMD_GRANT, 1'b1, 32'h0, 8'($urandom), 8'($urandom));
    send_event(CMD_MEM, 1'b0, 32'h0, 8'($urandom), 8'hFF);
    // snoop miss
    send_event(CMD_SNOOP, 1'b1, 32'h1234_5678, 8'($urandom), 8'($urandom));
    // read miss, with a second request dropped while busy
    send_event(CMD_CPU, 1'b1, 32'h0, 8'($urandom), 8'($urandom));
    send_event(CMD_CPU, 1'b0, 32'hFFFF_FFFF, 8'($urandom), 8'($urandom));
    send_event(CMD_GRANT, 1'b0, 32'($urandom), 8'($urandom), 8'($urandom));
    send_event(CMD_MEM, 1'b0, 32'($urandom), 8'($urandom), 8'hFF);
    // read hit, then write hit in shared with a remote write before the fill
    send_event(CMD_CPU, 1'b1, 32'h0, 8'($urandom), 8'($urandom));
    send_event(CMD_CPU, 1'b0, 32'h0, 8'h5A, 8'($urandom));
    send_event(CMD_SNOOP, 1'b0, 32'h0, 8'($urandom), 8'($urandom));
    send_event(CMD_GRANT, 1'b1, 32'($urandom), 8'($urandom), 8'($urandom));
    send_event(CMD_MEM, 1'b1, 32'($urandom), 8'($urandom), 8'h00);
    // write hit in modified, then remote reads
    send_event(CMD_CPU, 1'b0, 32'h0, 8'hA5, 8'($urandom));
    send_event(CMD_SNOOP, 1'b1, 32'h0, 8'($urandom), 8'($urandom));
    send_event(CMD_SNOOP, 1'b1, 32'h0, 8'($urandom), 8'($urandom));
    // upgrade whose fill hits the pending address
    send_event(CMD_CPU, 1'b0, 32'h0, 8'h00, 8'($urandom));
    send_event(CMD_GRANT, 1'b1, 32'($urandom), 8'($urandom), 8'($urandom));
    send_event(CMD_MEM, 1'b0, 32'($urandom), 8'($urandom), 8'hFF);
    // read miss that evicts a dirty line
    send_event(CMD_CPU, 1'b1, 32'hFFFF_FFFF, 8'($urandom), 8'($urandom));
    send_event(CMD_GRANT, 1'b0, 32'($urandom), 8'($urandom), 8'($urandom));
    send_event(CMD_MEM, 1'b1, 32'($urandom), 8'($urandom), 8'h00);
    // write miss over a shared line, then remote write of the dirty line
    send_event(CMD_CPU, 1'b0, 32'h0, 8'hFF, 8'($urandom));
    send_event(CMD_GRANT, 1'b1, 32'($urandom), 8'($urandom), 8'($urandom));
    send_event(CMD_MEM, 1'b0, 32'($urandom), 8'($urandom), 8'($urandom));
    send_event(CMD_SNOOP, 1'b0, 32'h0, 8'($urandom), 8'($urandom));
    wait_drained();

    // random phases, each under its own cache_id
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       id = '0;
        1:       id = ID_W'($urandom_range(14, 1));
        default: id = '1;
      endcase
      gaps_on = (phase != 1);
      write_cache_id(id);
      if (phase == 2) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      target = sent_words + CHUNK_WORDS;
      while (sent_words < target) rand_sequence();
      wait_drained();
    end

    $display("covered %0d input words and %0d result words under %0d cache_id settings",
             sent_words, checked_words, settings_used);
    $display("with a long output hold-off, a stretch without idling and drains between settings");
    if (error_count == 0 && pending_words == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
